### design/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and fixed-point helpers for the tridiagonal sweep solver.
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int FixW = 48;
	localparam int IdxW = 6;

	typedef logic signed [FixW-1:0] fix_t;
	typedef logic [IdxW-1:0]        idx_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_LEFT_BOUNDARY  = 1'b0,
		REG_RIGHT_BOUNDARY = 1'b1
	} cfg_reg_t;

	// one input transaction: one interior row
	typedef struct packed {
		fix_t coef_lower;
		fix_t coef_diag;
		fix_t coef_upper;
		fix_t rhs;
		logic row_last;
	} row_item_t;

	// one result transaction: one node value
	typedef struct packed {
		idx_t node_index;
		fix_t node_value;
		logic fault;
		logic result_last;
	} node_item_t;

	// classified row as queued between front and back
	typedef struct packed {
		row_item_t item;
		idx_t      idx;
		logic      last;
	} row_job_t;

	// front to back queue head
	typedef struct packed {
		logic     valid;
		row_job_t job;
	} row_link_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL_A,
		ST_MUL_A_WAIT,
		ST_PIVOT,
		ST_MUL_B,
		ST_MUL_B_WAIT,
		ST_DIV,
		ST_DIV_WAIT,
		ST_ROW_END,
		ST_BACK_READ,
		ST_BACK_MUL,
		ST_BACK_WAIT,
		ST_EMIT_READ,
		ST_EMIT
	} sweep_state_t;

	localparam fix_t FixMax = {1'b0, {(FixW-1){1'b1}}};
	localparam fix_t FixMin = {1'b1, {(FixW-1){1'b0}}};

	// saturate a 49-bit sum to 48 bits
	function automatic fix_t sat49(input logic signed [FixW:0] v);
		fix_t r;
		if (v[FixW] != v[FixW-1]) begin
			r = v[FixW] ? FixMin : FixMax;
		end else begin
			r = v[FixW-1:0];
		end
		return r;
	endfunction

	function automatic logic ovf49(input logic signed [FixW:0] v);
		return v[FixW] != v[FixW-1];
	endfunction

	// unsigned magnitude; the most negative value maps to 2^47
	function automatic logic [FixW-1:0] mag48(input fix_t a);
		logic [FixW-1:0] u;
		u = a;
		return a[FixW-1] ? (~u + 48'd1) : u;
	endfunction

	// restore the sign of a magnitude with saturation
	function automatic fix_t apply_sign(input logic [63:0] mag, input logic neg);
		logic [63:0] nm;
		fix_t r;
		nm = ~mag + 64'd1;
		if (neg) begin
			r = (mag > 64'h0000_8000_0000_0000) ? FixMin : nm[FixW-1:0];
		end else begin
			r = (mag > 64'h0000_7FFF_FFFF_FFFF) ? FixMax : mag[FixW-1:0];
		end
		return r;
	endfunction

	function automatic logic apply_sign_ovf(input logic [63:0] mag, input logic neg);
		return neg ? (mag > 64'h0000_8000_0000_0000) : (mag > 64'h0000_7FFF_FFFF_FFFF);
	endfunction

endpackage

### design/tss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_front
// Takes row transactions, tags each with its row index and effective last
// flag, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tss_front #(
	parameter int MAX_INTERVALS = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tss_pkg::row_item_t row,
	output tss_pkg::row_link_t link,
	input  logic               link_pop
);
	import tss_pkg::*;

	localparam int Depth = 2;

	row_job_t   fifo_q [Depth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	idx_t       row_cnt_q;

	logic     accept;
	logic     take;
	logic     force_last;
	row_job_t job_in;

	// classify the incoming row
	always_comb begin
		accept     = push && !full;
		take       = link_pop && link.valid;
		force_last = (({1'b0, row_cnt_q} + 7'd1) >= 7'(MAX_INTERVALS - 1));
		job_in.item = row;
		job_in.idx  = row_cnt_q;
		job_in.last = row.row_last || force_last;
	end

	assign full       = (count_q == 2'd2);
	assign link.valid = (count_q != 2'd0);
	assign link.job   = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= job_in;
		end
	end

	// pointers, occupancy and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			count_q   <= 2'd0;
			row_cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q  <= ~wr_ptr_q;
				row_cnt_q <= job_in.last ? '0 : row_cnt_q + 6'd1;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({accept, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/tss_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_mul
// Q16.32 saturating multiply; four 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module tss_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tss_pkg::fix_t a,
	input  tss_pkg::fix_t b,
	output logic          done,
	output tss_pkg::fix_t res,
	output logic          ovf
);
	import tss_pkg::*;

	logic [FixW-1:0] ma_q;
	logic [FixW-1:0] mb_q;
	logic            neg_q;
	logic [63:0]     acc_q;
	logic [1:0]      step_q;
	logic            busy_q;
	logic            done_q;

	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] prod;
	logic [63:0] term;

	// partial product select: hi*hi, hi*lo, lo*hi, lo*lo
	always_comb begin
		op_x = (step_q[1] == 1'b0) ? {16'd0, ma_q[47:32]} : ma_q[31:0];
		op_y = (step_q[0] == 1'b0) ? {16'd0, mb_q[47:32]} : mb_q[31:0];
		prod = {32'd0, op_x} * {32'd0, op_y};
		case (step_q)
			2'd0:    term = prod << 32;
			2'd3:    term = prod >> 32;
			default: term = prod;
		endcase
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag48(a);
			mb_q  <= mag48(b);
			neg_q <= a[FixW-1] ^ b[FixW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + term;
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = apply_sign(acc_q, neg_q);
	assign ovf  = apply_sign_ovf(acc_q, neg_q);

endmodule

### design/tss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_div
// Q16.32 saturating divide (n * 2^32) / d, restoring, two quotient bits a
// cycle over an 80-bit dividend. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module tss_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tss_pkg::fix_t n,
	input  tss_pkg::fix_t d,
	output logic          done,
	output tss_pkg::fix_t q,
	output logic          ovf
);
	import tss_pkg::*;

	localparam int DvdW   = 80;
	localparam int Radix  = 2;
	localparam int Cycles = DvdW / Radix;
	localparam logic [FixW+1:0] QuoCap = 50'h1_0000_0000_0000;

	logic [DvdW-1:0] dvd_q;
	logic [FixW-1:0] md_q;
	logic [FixW:0]   rem_q;
	logic [FixW:0]   quo_q;
	logic            neg_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [FixW:0]   rem_v;
	logic [FixW+1:0] quo_v;
	logic [DvdW-1:0] dvd_v;

	// two restoring steps; quotient clamps at 2^48
	always_comb begin
		rem_v = rem_q;
		quo_v = {1'b0, quo_q};
		dvd_v = dvd_q;
		for (int j = 0; j < Radix; j++) begin
			rem_v = {rem_v[FixW-1:0], dvd_v[DvdW-1]};
			dvd_v = {dvd_v[DvdW-2:0], 1'b0};
			quo_v = {quo_v[FixW:0], 1'b0};
			if (rem_v >= {1'b0, md_q}) begin
				rem_v    = rem_v - {1'b0, md_q};
				quo_v[0] = 1'b1;
			end
			if (quo_v > QuoCap) begin
				quo_v = QuoCap;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag48(n), 32'd0};
			md_q  <= mag48(d);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= n[FixW-1] ^ d[FixW-1];
		end else if (busy_q) begin
			dvd_q <= dvd_v;
			rem_q <= rem_v;
			quo_q <= quo_v[FixW:0];
		end
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(Cycles - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign q    = apply_sign({15'd0, quo_q}, neg_q);
	assign ovf  = apply_sign_ovf({15'd0, quo_q}, neg_q);

endmodule

### design/tss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_back
// Sequencer for the forward sweep, back substitution and result output.
// Holds the alpha, beta and node value memories and the output register.
// ----------------------------------------------------------------------------
module tss_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tss_pkg::row_link_t  link,
	output logic                link_pop,
	input  tss_pkg::fix_t       left_boundary,
	input  tss_pkg::fix_t       right_boundary,
	output tss_pkg::node_item_t node,
	output logic                empty,
	input  logic                pop
);
	import tss_pkg::*;

	localparam int NodeDepth = 2 ** IdxW;

	sweep_state_t state_q;
	sweep_state_t state_d;

	fix_t alpha_mem [NodeDepth];
	fix_t beta_mem  [NodeDepth];
	fix_t v_mem     [NodeDepth];

	row_job_t   row_q;
	fix_t       alpha_rd_q;
	fix_t       beta_rd_q;
	fix_t       v_rd_q;
	fix_t       piv_q;
	fix_t       x_q;
	fix_t       v_q;
	idx_t       k_q;
	idx_t       e_q;
	logic       fault_q;
	node_item_t out_q;
	logic       out_valid_q;

	idx_t rd_addr;
	logic ab_we;
	idx_t ab_addr;
	fix_t alpha_wd;
	fix_t beta_wd;
	logic v_we;
	idx_t v_addr;
	fix_t v_wd;

	logic mul_start;
	fix_t mul_a;
	fix_t mul_b;
	logic mul_done;
	fix_t mul_res;
	logic mul_ovf;

	logic div_start;
	logic diva_done;
	logic divb_done;
	fix_t diva_q;
	fix_t divb_q;
	logic diva_ovf;
	logic divb_ovf;

	fix_t                alpha_op;
	fix_t                beta_op;
	logic signed [FixW:0] piv_sum;
	logic signed [FixW:0] x_sum;
	logic signed [FixW:0] bk_sum;
	idx_t                n_idx;
	logic                out_free;

	// shared multiplier and the two dividers (alpha and beta)
	tss_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res),
		.ovf    (mul_ovf)
	);

	tss_div u_div_alpha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (row_q.item.coef_upper),
		.d      (piv_q),
		.done   (diva_done),
		.q      (diva_q),
		.ovf    (diva_ovf)
	);

	tss_div u_div_beta (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (x_q),
		.d      (piv_q),
		.done   (divb_done),
		.q      (divb_q),
		.ovf    (divb_ovf)
	);

	// arithmetic around the multiplier
	always_comb begin
		alpha_op = (row_q.idx == '0) ? '0 : alpha_rd_q;
		beta_op  = (row_q.idx == '0) ? left_boundary : beta_rd_q;
		piv_sum  = {row_q.item.coef_diag[FixW-1], row_q.item.coef_diag}
			- {mul_res[FixW-1], mul_res};
		x_sum    = {mul_res[FixW-1], mul_res} + {row_q.item.rhs[FixW-1], row_q.item.rhs};
		bk_sum   = {mul_res[FixW-1], mul_res} + {beta_rd_q[FixW-1], beta_rd_q};
		n_idx    = row_q.idx + 6'd2;
		out_free = !out_valid_q || pop;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (link.valid) state_d = ST_READ;
			ST_READ:       state_d = ST_MUL_A;
			ST_MUL_A:      state_d = ST_MUL_A_WAIT;
			ST_MUL_A_WAIT: if (mul_done) state_d = ST_PIVOT;
			ST_PIVOT:      state_d = (piv_q == '0) ? ST_ROW_END : ST_MUL_B;
			ST_MUL_B:      state_d = ST_MUL_B_WAIT;
			ST_MUL_B_WAIT: if (mul_done) state_d = ST_DIV;
			ST_DIV:        state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:   if (diva_done) state_d = ST_ROW_END;
			ST_ROW_END:    state_d = row_q.last ? ST_BACK_READ : ST_IDLE;
			ST_BACK_READ:  state_d = ST_BACK_MUL;
			ST_BACK_MUL:   state_d = ST_BACK_WAIT;
			ST_BACK_WAIT: begin
				if (mul_done) state_d = (k_q == 6'd1) ? ST_EMIT_READ : ST_BACK_READ;
			end
			ST_EMIT_READ:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = (e_q == '0) ? ST_IDLE : ST_EMIT_READ;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// control strobes and memory ports
	always_comb begin
		link_pop  = 1'b0;
		ab_we     = 1'b0;
		ab_addr   = row_q.idx + 6'd1;
		alpha_wd  = diva_q;
		beta_wd   = divb_q;
		v_we      = 1'b0;
		v_addr    = k_q - 6'd1;
		v_wd      = sat49(bk_sum);
		mul_start = 1'b0;
		mul_a     = row_q.item.coef_lower;
		mul_b     = v_q;
		div_start = 1'b0;
		rd_addr   = row_q.idx;
		unique case (state_q)
			ST_IDLE:       link_pop = link.valid;
			ST_READ: begin
				// first row of a solve seeds entry zero
				if (row_q.idx == '0) begin
					ab_we    = 1'b1;
					ab_addr  = '0;
					alpha_wd = '0;
					beta_wd  = left_boundary;
				end
			end
			ST_MUL_A: begin
				mul_start = 1'b1;
				mul_b     = alpha_op;
			end
			ST_MUL_A_WAIT: mul_b = alpha_op;
			ST_PIVOT: begin
				// zero pivot: next alpha and beta are zero
				if (piv_q == '0) begin
					ab_we    = 1'b1;
					alpha_wd = '0;
					beta_wd  = '0;
				end
			end
			ST_MUL_B: begin
				mul_start = 1'b1;
				mul_b     = beta_op;
			end
			ST_MUL_B_WAIT: mul_b = beta_op;
			ST_DIV:        div_start = 1'b1;
			ST_DIV_WAIT:   ab_we = diva_done;
			ST_ROW_END: begin
				if (row_q.last) begin
					v_we   = 1'b1;
					v_addr = n_idx;
					v_wd   = right_boundary;
				end
			end
			ST_BACK_READ:  rd_addr = k_q - 6'd1;
			ST_BACK_MUL: begin
				rd_addr   = k_q - 6'd1;
				mul_start = 1'b1;
				mul_a     = alpha_rd_q;
			end
			ST_BACK_WAIT: begin
				rd_addr = k_q - 6'd1;
				mul_a   = alpha_rd_q;
				v_we    = mul_done;
			end
			ST_EMIT_READ:  rd_addr = e_q;
			ST_EMIT:       rd_addr = e_q;
			default:       link_pop = 1'b0;
		endcase
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (ab_we) begin
			alpha_mem[ab_addr] <= alpha_wd;
			beta_mem[ab_addr]  <= beta_wd;
		end
		alpha_rd_q <= alpha_mem[rd_addr];
		beta_rd_q  <= beta_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			v_mem[v_addr] <= v_wd;
		end
		v_rd_q <= v_mem[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && link.valid) begin
			row_q <= link.job;
		end
		if (state_q == ST_MUL_A_WAIT && mul_done) begin
			piv_q <= sat49(piv_sum);
		end
		if (state_q == ST_MUL_B_WAIT && mul_done) begin
			x_q <= sat49(x_sum);
		end
		if (state_q == ST_ROW_END) begin
			v_q <= right_boundary;
			k_q <= n_idx;
			e_q <= n_idx;
		end
		if (state_q == ST_BACK_WAIT && mul_done) begin
			v_q <= sat49(bk_sum);
			k_q <= k_q - 6'd1;
		end
		if (state_q == ST_EMIT && out_free) begin
			e_q                <= e_q - 6'd1;
			out_q.node_index   <= e_q;
			out_q.node_value   <= v_rd_q;
			out_q.fault        <= fault_q;
			out_q.result_last  <= (e_q == '0);
		end
	end

	// state, sticky fault and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_MUL_A_WAIT: if (mul_done) fault_q <= fault_q | mul_ovf | ovf49(piv_sum);
				ST_PIVOT:      if (piv_q == '0) fault_q <= 1'b1;
				ST_MUL_B_WAIT: if (mul_done) fault_q <= fault_q | mul_ovf | ovf49(x_sum);
				ST_DIV_WAIT:   if (diva_done) fault_q <= fault_q | diva_ovf | divb_ovf;
				ST_BACK_WAIT:  if (mul_done) fault_q <= fault_q | mul_ovf | ovf49(bk_sum);
				ST_EMIT:       if (out_free && e_q == '0) fault_q <= 1'b0;
				default:       fault_q <= fault_q;
			endcase
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign node  = out_q;
	assign empty = !out_valid_q;

endmodule

### design/tridiagonal_sweep_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_sweep_solver
// Thomas-method solver for -A*v[i-1] + C*v[i] - B*v[i+1] = F in Q16.32.
// ----------------------------------------------------------------------------
// Rows go in one transaction each; a row that is not last returns nothing. In
// the back end a row runs two multiplies on the shared 32x32 multiplier and a
// division (alpha and beta divided side by side, two quotient bits a cycle); a
// zero pivot skips the second multiply and the division. The front queue holds
// two rows, so up to two more rows can be pushed while one is swept. After the
// last row (marked, or forced once MAX_INTERVALS-1 rows are in), back
// substitution computes one node value at a time, all values are computed
// before the first result so that the fault bit is final, and then results are
// offered one at a time from node N down to node 0. The memories need no clearing after reset.
// ----------------------------------------------------------------------------
module tridiagonal_sweep_solver #(
	parameter int MAX_INTERVALS = 63
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tss_pkg::row_item_t  row,
	output logic                empty,
	input  logic                pop,
	output tss_pkg::node_item_t node,
	input  logic                cfg_we,
	input  tss_pkg::cfg_reg_t   cfg_index,
	input  tss_pkg::fix_t       cfg_data
);
	import tss_pkg::*;

	fix_t      left_q;
	fix_t      right_q;
	row_link_t link;
	logic      link_pop;

	// boundary registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT_BOUNDARY:  left_q  <= cfg_data;
				REG_RIGHT_BOUNDARY: right_q <= cfg_data;
			endcase
		end
	end

	tss_front #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.row      (row),
		.link     (link),
		.link_pop (link_pop)
	);

	tss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.link           (link),
		.link_pop       (link_pop),
		.left_boundary  (left_q),
		.right_boundary (right_q),
		.node           (node),
		.empty          (empty),
		.pop            (pop)
	);

`ifndef SYNTH
	// the closing result of a run is node zero
	a_last_is_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && node.result_last) |-> (node.node_index == '0))
		else $error("result_last on a nonzero node");

	// back end only takes a row the front has queued
	a_pop_from_filled: assert property (@(posedge clk) disable iff (!arst_n)
		link_pop |-> link.valid)
		else $error("row queue popped while empty");

	// node index stays within the interval limit
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (node.node_index <= 6'(MAX_INTERVALS)))
		else $error("node index beyond interval limit");
`endif

endmodule

### tb/sv/tridiagonal_sweep_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_sweep_solver_tb
// Self-checking bench for the Thomas-method tridiagonal solver.
// ----------------------------------------------------------------------------
// Rows are pushed as transactions. A class keeps its own copy of the sweep
// state and boundaries and computes the node values that each closing row
// should release. Every popped node is checked against the oldest expected
// node. There are three idling phases, and a long receiver hold-off fills the
// block. Boundaries are only rewritten once the solver has drained.
// ----------------------------------------------------------------------------
module tridiagonal_sweep_solver_tb;
	import tss_pkg::*;

	localparam int MaxIntervals = 63;
	localparam longint FxMax = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint FxMin = -FxMax - 1;
	localparam int CycleLimit = 2000000;

	// sweep predictor and expected node store
	class sweep_scoreboard;
		longint alpha_mem[64];
		longint beta_mem[64];
		int rows_in_solve;
		bit sticky_fault;
		longint left_bc, right_bc;
		node_item_t pending_nodes[$];
		int errors, nodes_checked, rows_seen, solves_done;

		function void set_cfg(cfg_reg_t idx, fix_t data);
			if (idx == REG_LEFT_BOUNDARY) begin
				left_bc = longint'(data);
			end else begin
				right_bc = longint'(data);
			end
		endfunction

		function longint sat(longint v);
			if (v > FxMax) begin
				sticky_fault = 1;
				return FxMax;
			end
			if (v < FxMin) begin
				sticky_fault = 1;
				return FxMin;
			end
			return v;
		endfunction

		function longint signed_mag(bit [63:0] m, bit neg);
			if (neg) begin
				if (m > 64'h0000_8000_0000_0000) begin
					sticky_fault = 1;
					return FxMin;
				end
				return -$signed(m);
			end
			if (m > 64'h0000_7FFF_FFFF_FFFF) begin
				sticky_fault = 1;
				return FxMax;
			end
			return $signed(m);
		endfunction

		function bit [63:0] abs64(longint a);
			return a < 0 ? 64'd0 - a : a;
		endfunction

		// Q16.32 product, truncated toward zero
		function longint q_mul(longint a, longint b);
			bit [63:0] ma, mb, q;
			ma = abs64(a);
			mb = abs64(b);
			q = (((ma >> 32) * (mb >> 32)) << 32) + (ma >> 32) * mb[31:0]
				+ ma[31:0] * (mb >> 32) + ((ma[31:0] * mb[31:0]) >> 32);
			return signed_mag(q, (a < 0) != (b < 0));
		endfunction

		// Q16.32 quotient, restoring division over 80 dividend bits
		function longint q_div(longint n, longint d);
			bit [63:0] mn, md, hi, lo, rem, q;
			bit nb;
			if (d == 0) begin
				sticky_fault = 1;
				return 0;
			end
			mn = abs64(n);
			md = abs64(d);
			hi = mn >> 32;
			lo = mn << 32;
			rem = 0;
			q = 0;
			for (int b = 79; b >= 0; b--) begin
				nb = b >= 64 ? hi[b-64] : lo[b];
				rem = (rem << 1) | nb;
				q = q << 1;
				if (rem >= md) begin
					rem = rem - md;
					q[0] = 1;
				end
				if (q > 64'h0001_0000_0000_0000) q = 64'h0001_0000_0000_0000;
			end
			return signed_mag(q, (n < 0) != (d < 0));
		endfunction

		// forward sweep for one accepted row; a closing row queues its nodes
		function void note_row(row_item_t r);
			longint a, c, bu, f, piv;
			longint v[64];
			int i, cnt, n;
			bit last;
			a = longint'(r.coef_lower);
			c = longint'(r.coef_diag);
			bu = longint'(r.coef_upper);
			f = longint'(r.rhs);
			last = r.row_last;
			i = rows_in_solve;
			rows_seen++;
			if (i == 0) begin
				alpha_mem[0] = 0;
				beta_mem[0] = left_bc;
			end
			piv = sat(c - q_mul(a, alpha_mem[i]));
			if (piv == 0) begin
				sticky_fault = 1;
				alpha_mem[(i + 1) % 64] = 0;
				beta_mem[(i + 1) % 64] = 0;
			end else begin
				alpha_mem[(i + 1) % 64] = q_div(bu, piv);
				beta_mem[(i + 1) % 64] = q_div(sat(q_mul(a, beta_mem[i]) + f), piv);
			end
			cnt = i + 1;
			if (cnt >= MaxIntervals - 1) last = 1;
			if (!last) begin
				rows_in_solve = cnt % 64;
				return;
			end
			// back substitution from the right boundary down to node zero
			n = (cnt + 1) % 64;
			v[n] = right_bc;
			for (int k = n; k > 0; k--) begin
				v[k-1] = sat(q_mul(alpha_mem[k-1], v[k]) + beta_mem[k-1]);
			end
			for (int k = n; k >= 0; k--) begin
				node_item_t e;
				e.node_index = idx_t'(k);
				e.node_value = fix_t'(v[k]);
				e.fault = sticky_fault;
				e.result_last = (k == 0);
				pending_nodes.push_back(e);
			end
			rows_in_solve = 0;
			sticky_fault = 0;
			solves_done++;
		endfunction

		function void check_node(node_item_t got);
			node_item_t e;
			if (pending_nodes.size() == 0) begin
				$display("%0t: unexpected node transaction %p", $time, got);
				errors++;
				return;
			end
			e = pending_nodes.pop_front();
			nodes_checked++;
			if (got.node_index !== e.node_index)
				$display("%0t: node_index expected %0d got %0d", $time,
					e.node_index, got.node_index);
			if (got.node_value !== e.node_value)
				$display("%0t: node_value at %0d expected %h got %h", $time,
					e.node_index, e.node_value, got.node_value);
			if (got.fault !== e.fault)
				$display("%0t: fault at %0d expected %b got %b", $time,
					e.node_index, e.fault, got.fault);
			if (got.result_last !== e.result_last)
				$display("%0t: result_last at %0d expected %b got %b", $time,
					e.node_index, e.result_last, got.result_last);
			if (got !== e) errors++;
		endfunction
	endclass

	logic clk, arst_n, push, full, empty, pop, cfg_we;
	row_item_t row;
	node_item_t node;
	cfg_reg_t cfg_index;
	fix_t cfg_data;

	sweep_scoreboard sb;
	int send_idle, recv_idle, hold_cycles, cycles, rows_sent;

	tridiagonal_sweep_solver #(.MAX_INTERVALS(MaxIntervals)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .row(row),
		.empty(empty), .pop(pop), .node(node),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tridiagonal_sweep_solver test failed");
			$finish;
		end
	end

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_row(row);
			if (pop && !empty) sb.check_node(node);
		end
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		pop = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				pop = 0;
				hold_cycles--;
			end else begin
				pop = ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic fix_t rnd_fix(int bits);
		fix_t v;
		v = fix_t'({$urandom, $urandom});
		return v >>> (48 - bits);
	endfunction

	// diagonally dominant row with random content
	function automatic row_item_t good_row(bit last);
		row_item_t r;
		longint a, b, c;
		a = longint'(rnd_fix(34));
		b = longint'(rnd_fix(34));
		c = (a < 0 ? -a : a) + (b < 0 ? -b : b) + $urandom_range(1, 1 << 30) * 64'd8;
		if ($urandom_range(1)) c = -c;
		r.coef_lower = fix_t'(a);
		r.coef_upper = fix_t'(b);
		r.coef_diag = fix_t'(c);
		r.rhs = rnd_fix($urandom_range(20, 44));
		r.row_last = last;
		return r;
	endfunction

	function automatic row_item_t noise_row(bit last);
		row_item_t r;
		r.coef_lower = rnd_fix(48);
		r.coef_diag = rnd_fix(48);
		r.coef_upper = rnd_fix(48);
		r.rhs = rnd_fix(48);
		r.row_last = last;
		return r;
	endfunction

	function automatic row_item_t mk_row(longint a, longint c, longint b, longint f,
			bit last);
		row_item_t r;
		r.coef_lower = fix_t'(a);
		r.coef_diag = fix_t'(c);
		r.coef_upper = fix_t'(b);
		r.rhs = fix_t'(f);
		r.row_last = last;
		return r;
	endfunction

	// offer one row; called and returns at a falling edge
	task automatic send_row(row_item_t r);
		while ($urandom_range(99) < send_idle) begin
			push = 0;
			@(negedge clk);
		end
		push = 1;
		row = r;
		// full only moves at a rising edge, so its value here holds for the next one
		while (full) @(negedge clk);
		@(posedge clk);
		rows_sent++;
		@(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, fix_t data);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = data;
		sb.set_cfg(idx, data);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// hold the sender until every node has come out, then let the solver settle
	task automatic drain();
		push = 0;
		while (sb.pending_nodes.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// one solve of random length; a very long one runs into the forced end
	task automatic random_solve();
		int len;
		bit lst;
		len = ($urandom_range(99) < 3) ? 70 : $urandom_range(1, 8);
		for (int k = 0; k < len && k < MaxIntervals - 1; k++) begin
			lst = (k == len - 1);
			if ($urandom_range(99) < 10) send_row(noise_row(lst));
			else send_row(good_row(lst));
		end
	endtask

	initial begin
		sb = new();
		push = 0;
		row = '0;
		cfg_we = 0;
		cfg_index = REG_LEFT_BOUNDARY;
		cfg_data = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		cycles = 0;
		rows_sent = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extreme boundaries, zero pivot, saturation, plain solves
		write_cfg(REG_LEFT_BOUNDARY, fix_t'(FxMax));
		write_cfg(REG_RIGHT_BOUNDARY, fix_t'(FxMin));
		send_row(mk_row(FxMax, FxMin, FxMax, FxMin, 1));
		send_row(mk_row(FxMin, FxMax, FxMin, FxMax, 1));
		send_row(mk_row(64'sd1 << 32, 0, 64'sd1 << 32, 64'sd5 << 32, 0));
		send_row(mk_row(64'sd1 << 32, 64'sd4 << 32, 64'sd1 << 32, 64'sd2 << 32, 1));
		send_row(mk_row(0, 1, FxMax, FxMax, 0));
		send_row(mk_row(FxMax, 64'sd2 << 32, 0, 1, 1));
		send_row(mk_row(-1, -1, -1, -1, 1));
		drain();
		write_cfg(REG_LEFT_BOUNDARY, fix_t'(64'sd3 << 32));
		write_cfg(REG_RIGHT_BOUNDARY, fix_t'(-(64'sd7 << 31)));
		for (int k = 0; k < 4; k++) send_row(good_row(k == 3));
		send_row(noise_row(1));
		send_row(mk_row(0, 0, 0, 0, 1));
		drain();

		// random phases with different idling and boundaries
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 33 : (ph == 1) ? 60 : 0;
			recv_idle = (ph == 0) ? 60 : (ph == 1) ? 33 : 0;
			write_cfg(REG_LEFT_BOUNDARY,
				(ph == 1) ? fix_t'(FxMin) : rnd_fix($urandom_range(8, 48)));
			write_cfg(REG_RIGHT_BOUNDARY,
				(ph == 2) ? fix_t'(FxMax) : rnd_fix($urandom_range(8, 48)));
			if (ph == 2) hold_cycles = 1500;
			while (rows_sent < 25 + 115 * (ph + 1)) random_solve();
			drain();
		end

		@(negedge clk);
		$display("rows sent %0d, solves %0d, nodes checked %0d, mismatches %0d",
			sb.rows_seen, sb.solves_done, sb.nodes_checked, sb.errors);
		if (sb.errors == 0 && sb.pending_nodes.size() == 0) begin
			$display("tridiagonal_sweep_solver test passed");
		end else begin
			$display("tridiagonal_sweep_solver test failed");
		end
		$finish;
	end

endmodule
